[rtl/hdr_tone_mapper_top_macros.svh]
// ----------------------------------------------------------------------------
// hdr_tone_mapper_top_macros.svh
// Assertion macros shared by the tone mapper RTL.
// ----------------------------------------------------------------------------
`ifndef HDR_TONE_MAPPER_TOP_MACROS_SVH
`define HDR_TONE_MAPPER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define HTM_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`define HTM_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`else
`define HTM_ASSERT(lbl, cond, msg)
`define HTM_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[rtl/htm_pkg.sv]
// ----------------------------------------------------------------------------
// htm_pkg
// Types, constants and the exposure table of the HDR tone mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package htm_pkg;

   typedef logic signed [23:0] hdr_type;   // signed Q7.16 input channel
   typedef logic [22:0]        lin_type;   // non-negative Q7.16 after clamp
   typedef logic [16:0]        q16_type;   // Q0.16, 65536 = 1.0

   typedef struct packed {
      q16_type red;
      q16_type green;
      q16_type blue;
   } rgb_out_type;

   localparam int FIFO_DEPTH = 32;
   localparam int PTR_W      = 5;
   localparam int CNT_W      = 6;

   localparam q16_type Q_ONE      = 17'd65536;
   localparam logic [22:0] PBR_START  = 23'd49807;
   localparam logic [22:0] PBR_SHIFT  = 23'd34078;   // start - D
   localparam logic [22:0] PBR_D      = 23'd15729;
   localparam logic [28:0] PBR_D_SQ   = 29'd247401441;
   localparam logic [22:0] PBR_KNEE   = 23'd5243;    // 0.08
   localparam logic [12:0] PBR_OFF    = 13'd2621;    // 0.04
   localparam logic [36:0] PBR_DESAT  = 37'd9830;    // 0.15

   localparam logic [22:0] ACES_BIG   = 23'd524288;  // 8.0
   localparam logic [36:0] ACES_A     = 37'd164495;
   localparam logic [36:0] ACES_B_SH  = 37'd128843776;  // 0.03 in Q.32
   localparam logic [36:0] ACES_C     = 37'd159252;
   localparam logic [36:0] ACES_D_SH  = 37'd2534014976; // 0.59 in Q.32
   localparam logic [55:0] ACES_E_SH  = 56'd39406324940800; // 0.14 in Q.48

   // round(2^(f/16) * 65536)
   function automatic q16_type exp_frac(input logic [3:0] f);
      q16_type r;
      case (f)
         4'd0:  r = 17'd65536;
         4'd1:  r = 17'd68438;
         4'd2:  r = 17'd71468;
         4'd3:  r = 17'd74632;
         4'd4:  r = 17'd77936;
         4'd5:  r = 17'd81386;
         4'd6:  r = 17'd84990;
         4'd7:  r = 17'd88752;
         4'd8:  r = 17'd92682;
         4'd9:  r = 17'd96785;
         4'd10: r = 17'd101070;
         4'd11: r = 17'd105545;
         4'd12: r = 17'd110218;
         4'd13: r = 17'd115098;
         4'd14: r = 17'd120194;
         4'd15: r = 17'd125515;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

endpackage

[rtl/htm_ifs.sv]
// ----------------------------------------------------------------------------
// htm_ifs
// Valid/ready pixel channels of the tone mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface htm_req_if;
   import htm_pkg::*;
   logic    valid;
   logic    ready;
   hdr_type red_in;
   hdr_type green_in;
   hdr_type blue_in;
   modport source (output valid, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface htm_rsp_if;
   import htm_pkg::*;
   logic    valid;
   logic    ready;
   q16_type red_out;
   q16_type green_out;
   q16_type blue_out;
   modport source (output valid, red_out, green_out, blue_out, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

[rtl/htm_div.sv]
// ----------------------------------------------------------------------------
// htm_div
// Pipelined restoring divider, STEP quotient bits per stage, with sideband.
// Expects in_num < in_den * 2^QUO_W.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htm_div #(
   parameter int NUM_W  = 32,
   parameter int DEN_W  = 16,
   parameter int QUO_W  = 16,
   parameter int STEP   = 2,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_vld,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_vld,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);
   localparam int STAGES = (QUO_W + STEP - 1) / STEP;

   logic [NUM_W+DEN_W-1:0] num_ext;
   logic [DEN_W-1:0]       rem0;

   logic              vld_ff  [STAGES];
   logic [DEN_W-1:0]  rem_ff  [STAGES];
   logic [DEN_W-1:0]  den_ff  [STAGES];
   logic [QUO_W-1:0]  work_ff [STAGES];
   logic [SIDE_W-1:0] side_ff [STAGES];

   assign num_ext = {{DEN_W{1'b0}}, in_num};
   assign rem0    = num_ext[QUO_W +: DEN_W];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic              vld_src;
      logic [DEN_W-1:0]  rem_src;
      logic [DEN_W-1:0]  den_src;
      logic [QUO_W-1:0]  work_src;
      logic [SIDE_W-1:0] side_src;
      logic [DEN_W-1:0]  rem_in;
      logic [QUO_W-1:0]  work_in;
      logic [DEN_W:0]    trial;
      logic              ge;

      if (s == 0) begin : g_first
         assign vld_src  = in_vld;
         assign rem_src  = rem0;
         assign den_src  = in_den;
         assign work_src = in_num[QUO_W-1:0];
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign work_src = work_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      // dividend bits shift out of the top of work, quotient bits in at the bottom
      always_comb begin
         rem_in  = rem_src;
         work_in = work_src;
         trial   = '0;
         ge      = 1'b0;
         for (int j = 0; j < STEP; j++) begin
            if (s * STEP + j < QUO_W) begin
               trial   = {rem_in, work_in[QUO_W-1]};
               ge      = (trial >= {1'b0, den_src});
               work_in = {work_in[QUO_W-2:0], ge};
               rem_in  = ge ? DEN_W'(trial - {1'b0, den_src}) : trial[DEN_W-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_src;
         end
         rem_ff[s]  <= rem_in;
         den_ff[s]  <= den_src;
         work_ff[s] <= work_in;
         side_ff[s] <= side_src;
      end
   end

   assign out_vld  = vld_ff[STAGES-1];
   assign out_quo  = work_ff[STAGES-1];
   assign out_side = side_ff[STAGES-1];

endmodule

[rtl/htm_exp.sv]
// ----------------------------------------------------------------------------
// htm_exp
// One channel: clamp negatives, scale by 2^(EV/16), round and saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htm_exp (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_vld,
   input  htm_pkg::hdr_type in_raw,
   input  logic [7:0]       in_u,      // clamped EV + 128
   output logic             out_vld,
   output htm_pkg::lin_type out_lin
);
   import htm_pkg::*;

   lin_type     x;
   logic [39:0] p_in, p_ff;
   logic [3:0]  sh_ff;
   logic        vld1_ff, vld2_ff;
   logic [55:0] rnd;
   lin_type     lin_in, lin_ff;

   assign x    = in_raw[23] ? '0 : in_raw[22:0];
   assign p_in = {17'b0, x} * {23'b0, exp_frac(in_u[3:0])};

   // 2^k with k = s - 8 folded into one shift by s and a fixed >> 24
   assign rnd    = {1'b0, 55'(p_ff) << sh_ff} + 56'h80_0000;
   assign lin_in = (|rnd[55:47]) ? 23'h7F_FFFF : rnd[46:24];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
      end
      p_ff   <= p_in;
      sh_ff  <= in_u[7:4];
      lin_ff <= lin_in;
   end

   assign out_vld = vld2_ff;
   assign out_lin = lin_ff;

endmodule

[rtl/htm_pbr.sv]
// ----------------------------------------------------------------------------
// htm_pbr
// Neutral operator: black offset, peak compression, desaturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htm_pbr (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_vld,
   input  htm_pkg::lin_type in_red,
   input  htm_pkg::lin_type in_green,
   input  htm_pkg::lin_type in_blue,
   output logic             out_vld,
   output htm_pkg::q16_type out_red,
   output htm_pkg::q16_type out_green,
   output htm_pkg::q16_type out_blue
);
   import htm_pkg::*;

   // stage 1: darkest channel
   lin_type c1_ff [3];
   lin_type d1_ff;
   logic    v1_ff;
   lin_type d_in;

   // stage 2: black offset square term
   lin_type     c2_ff [3];
   logic [12:0] d2_ff;
   logic        small2_ff;
   logic [29:0] sq2_ff;
   logic        v2_ff;
   logic [25:0] sqr;
   logic [29:0] sq_in;

   // stage 3: offset color
   lin_type     col3_ff [3];
   logic        v3_ff;
   logic [29:0] sq_rnd;
   logic [12:0] off;

   // stage 4: peak
   lin_type col4_ff [3];
   lin_type peak4_ff;
   logic    big4_ff;
   logic    v4_ff;
   lin_type peak_in;

   // stage 5: new-peak division operands
   lin_type     col5_ff [3];
   lin_type     peak5_ff;
   logic        big5_ff;
   logic        v5_ff;
   logic [28:0] dnum5_ff;
   lin_type     dden5_ff;
   lin_type     dden_in;

   // divider 1
   logic        q1_vld;
   logic [13:0] q1;
   logic [92:0] q1_side;

   // stage 6
   lin_type col6_ff [3];
   lin_type peak6_ff;
   logic    big6_ff;
   logic    v6_ff;
   q16_type np6_ff;
   lin_type diff6_ff;
   q16_type np_in;

   // stage 7
   lin_type     col7_ff [3];
   logic [39:0] prod7_ff [3];
   logic [36:0] tm7_ff;
   q16_type     np7_ff;
   lin_type     peak7_ff;
   logic        big7_ff;
   logic        v7_ff;

   // stage 8: divider operands
   logic [36:0] tm_rnd;
   logic [20:0] t_in;
   logic [32:0] num2_8_ff;
   logic [20:0] t8_ff;
   logic [39:0] num3_8_ff [3];
   lin_type     col8_ff [3];
   lin_type     peak8_ff;
   q16_type     np8_ff;
   logic        big8_ff;
   logic        v8_ff;

   // dividers 2 and 3
   logic        q2_vld;
   logic [16:0] q2;
   logic [17:0] q2_side;
   logic        q3_vld [3];
   logic [16:0] q3 [3];
   lin_type     q3_side [3];
   logic        stage9_vld;
   q16_type     np_d;

   // stage 9
   q16_type desat9_ff;
   q16_type s9_ff [3];
   q16_type np9_ff;
   q16_type col9_ff [3];
   logic    big9_ff;
   logic    v9_ff;

   // stage 10
   logic [33:0] m10_ff [3];
   q16_type     s10_ff [3];
   q16_type     col10_ff [3];
   logic        big10_ff;
   logic        v10_ff;

   // stage 11
   logic [33:0] m_rnd [3];
   q16_type     o_in [3];
   q16_type     o11_ff [3];
   logic        v11_ff;

   lin_type c0 [3];
   assign c0[0] = in_red;
   assign c0[1] = in_green;
   assign c0[2] = in_blue;

   always_comb begin
      d_in = c0[0];
      if (c0[1] < d_in) d_in = c0[1];
      if (c0[2] < d_in) d_in = c0[2];
   end

   assign sqr   = {13'b0, d1_ff[12:0]} * {13'b0, d1_ff[12:0]};
   assign sq_in = {sqr, 4'b0} + {1'b0, sqr, 3'b0} + {4'b0, sqr};   // 25 * d^2

   assign sq_rnd = sq2_ff + 30'h2_0000;
   assign off    = small2_ff ? (d2_ff - {1'b0, sq_rnd[29:18]}) : PBR_OFF;

   always_comb begin
      peak_in = col3_ff[0];
      if (col3_ff[1] > peak_in) peak_in = col3_ff[1];
      if (col3_ff[2] > peak_in) peak_in = col3_ff[2];
   end

   // below the knee the divider result is unused; keep its operands in range
   assign dden_in = big4_ff ? (peak4_ff - PBR_SHIFT) : PBR_D;

   htm_div #(.NUM_W(29), .DEN_W(23), .QUO_W(14), .STEP(2), .SIDE_W(93)) u_div_peak (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (v5_ff),
      .in_num   (dnum5_ff),
      .in_den   (dden5_ff),
      .in_side  ({col5_ff[0], col5_ff[1], col5_ff[2], peak5_ff, big5_ff}),
      .out_vld  (q1_vld),
      .out_quo  (q1),
      .out_side (q1_side)
   );

   assign np_in = Q_ONE - {3'b0, q1};

   assign tm_rnd = tm7_ff + 37'd32768;
   assign t_in   = 21'd65536 + tm_rnd[36:16];

   htm_div #(.NUM_W(33), .DEN_W(21), .QUO_W(17), .STEP(2), .SIDE_W(18)) u_div_desat (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (v8_ff),
      .in_num   (num2_8_ff),
      .in_den   (t8_ff),
      .in_side  ({np8_ff, big8_ff}),
      .out_vld  (q2_vld),
      .out_quo  (q2),
      .out_side (q2_side)
   );

   for (genvar i = 0; i < 3; i++) begin : g_scale
      htm_div #(.NUM_W(40), .DEN_W(23), .QUO_W(17), .STEP(2), .SIDE_W(23)) u_div_scale (
         .clock    (clock),
         .reset    (reset),
         .in_vld   (v8_ff),
         .in_num   (num3_8_ff[i]),
         .in_den   (peak8_ff),
         .in_side  (col8_ff[i]),
         .out_vld  (q3_vld[i]),
         .out_quo  (q3[i]),
         .out_side (q3_side[i])
      );
   end

   assign stage9_vld = q2_vld & q3_vld[0] & q3_vld[1] & q3_vld[2];
   assign np_d       = q2_side[17:1];

   for (genvar i = 0; i < 3; i++) begin : g_out
      assign m_rnd[i] = m10_ff[i] + 34'd32768;
      assign o_in[i]  = big10_ff ? (s10_ff[i] + m_rnd[i][32:16]) : col10_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
      end else begin
         v1_ff  <= in_vld;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         v5_ff  <= v4_ff;
         v6_ff  <= q1_vld;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= stage9_vld;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      d1_ff     <= d_in;
      d2_ff     <= d1_ff[12:0];
      small2_ff <= (d1_ff < PBR_KNEE);
      sq2_ff    <= sq_in;
      peak4_ff  <= peak_in;
      big4_ff   <= (peak_in >= PBR_START);
      peak5_ff  <= peak4_ff;
      big5_ff   <= big4_ff;
      dden5_ff  <= dden_in;
      dnum5_ff  <= PBR_D_SQ + {7'b0, dden_in[22:1]};
      peak6_ff  <= q1_side[23:1];
      big6_ff   <= q1_side[0];
      np6_ff    <= np_in;
      diff6_ff  <= (q1_side[23:1] > {6'b0, np_in}) ? (q1_side[23:1] - {6'b0, np_in}) : '0;
      tm7_ff    <= {14'b0, diff6_ff} * PBR_DESAT;
      np7_ff    <= np6_ff;
      peak7_ff  <= peak6_ff;
      big7_ff   <= big6_ff;
      t8_ff     <= t_in;
      num2_8_ff <= {1'b1, 32'b0} | {13'b0, t_in[20:1]};
      peak8_ff  <= peak7_ff;
      np8_ff    <= np7_ff;
      big8_ff   <= big7_ff;
      desat9_ff <= Q_ONE - q2;
      np9_ff    <= np_d;
      big9_ff   <= q2_side[0];
      big10_ff  <= big9_ff;
      for (int i = 0; i < 3; i++) begin
         c1_ff[i]     <= c0[i];
         c2_ff[i]     <= c1_ff[i];
         col3_ff[i]   <= c2_ff[i] - {10'b0, off};
         col4_ff[i]   <= col3_ff[i];
         col5_ff[i]   <= col4_ff[i];
         col7_ff[i]   <= col6_ff[i];
         prod7_ff[i]  <= {17'b0, col6_ff[i]} * {23'b0, np6_ff};
         num3_8_ff[i] <= prod7_ff[i] + {18'b0, peak7_ff[22:1]};
         col8_ff[i]   <= col7_ff[i];
         s9_ff[i]     <= (q3[i] > np_d) ? np_d : q3[i];
         col9_ff[i]   <= q3_side[i][16:0];
         m10_ff[i]    <= {17'b0, np9_ff - s9_ff[i]} * {17'b0, desat9_ff};
         s10_ff[i]    <= s9_ff[i];
         col10_ff[i]  <= col9_ff[i];
         o11_ff[i]    <= o_in[i];
      end
      col6_ff[0] <= q1_side[92:70];
      col6_ff[1] <= q1_side[69:47];
      col6_ff[2] <= q1_side[46:24];
   end

   assign out_vld   = v11_ff;
   assign out_red   = o11_ff[0];
   assign out_green = o11_ff[1];
   assign out_blue  = o11_ff[2];

endmodule

[rtl/htm_aces.sv]
// ----------------------------------------------------------------------------
// htm_aces
// One channel of the fitted filmic rational curve, clamped to 0..1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htm_aces (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_vld,
   input  htm_pkg::lin_type in_x,
   output logic             out_vld,
   output htm_pkg::q16_type out_y
);
   import htm_pkg::*;

   logic        v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic        big1_ff, big2_ff, big3_ff, big4_ff, big5_ff;
   logic [18:0] x1_ff, x2_ff;
   logic [36:0] pa1_ff, pb1_ff;
   logic [36:0] a2_ff, b2_ff;
   logic [36:0] ahx3_ff, bhx3_ff;
   logic [37:0] alx3_ff, blx3_ff;
   logic [55:0] numf, denf;
   logic [39:0] num4_ff, den4_ff;
   logic [55:0] dv5_ff;
   logic [39:0] den5_ff;
   logic        q_vld;
   logic [17:0] q;
   logic        q_big;
   q16_type     y_in, y6_ff;

   // num = x * (a*x + b), den = x * (c*x + d) + e, in Q.48 then >> 16
   assign numf = {ahx3_ff, 19'b0} + {18'b0, alx3_ff};
   assign denf = {bhx3_ff, 19'b0} + {18'b0, blx3_ff} + ACES_E_SH;

   htm_div #(.NUM_W(56), .DEN_W(40), .QUO_W(18), .STEP(2), .SIDE_W(1)) u_div (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (v5_ff),
      .in_num   (dv5_ff),
      .in_den   (den5_ff),
      .in_side  (big5_ff),
      .out_vld  (q_vld),
      .out_quo  (q),
      .out_side (q_big)
   );

   assign y_in = (q_big || q > {1'b0, Q_ONE}) ? Q_ONE : q[16:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= in_vld;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= q_vld;
      end
      big1_ff <= (in_x >= ACES_BIG);
      x1_ff   <= in_x[18:0];
      pa1_ff  <= {18'b0, in_x[18:0]} * ACES_A;
      pb1_ff  <= {18'b0, in_x[18:0]} * ACES_C;
      big2_ff <= big1_ff;
      x2_ff   <= x1_ff;
      a2_ff   <= pa1_ff + ACES_B_SH;
      b2_ff   <= pb1_ff + ACES_D_SH;
      big3_ff <= big2_ff;
      ahx3_ff <= {19'b0, a2_ff[36:19]} * {18'b0, x2_ff};
      alx3_ff <= {19'b0, a2_ff[18:0]} * {19'b0, x2_ff};
      bhx3_ff <= {19'b0, b2_ff[36:19]} * {18'b0, x2_ff};
      blx3_ff <= {19'b0, b2_ff[18:0]} * {19'b0, x2_ff};
      big4_ff <= big3_ff;
      num4_ff <= numf[55:16];
      den4_ff <= denf[55:16];
      big5_ff <= big4_ff;
      dv5_ff  <= {num4_ff, 16'b0} + {17'b0, den4_ff[39:1]};
      den5_ff <= den4_ff;
      y6_ff   <= y_in;
   end

   assign out_vld = v6_ff;
   assign out_y   = y6_ff;

endmodule

[rtl/hdr_tone_mapper_top.sv]
// ----------------------------------------------------------------------------
// hdr_tone_mapper_top
// HDR pixel tone mapper: exposure, then neutral or filmic operator, Q0.16 out.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake   | payload
//  req_ch   | in  | valid/ready | red_in, green_in, blue_in (signed Q7.16)
//  rsp_ch   | out | valid/ready | red_out, green_out, blue_out (Q0.16)
//  csr_*    | in  | APB write   | 0x0 operator_select, 0x4 exposure_ev
//
// One pixel per clock sustained while req_ch.ready is high. Results land in a
// 32-beat output FIFO; req_ch.ready drops only when 32 pixels are accepted
// and not yet taken. Reset is synchronous and clears the settings, valid bits,
// FIFO pointers and counters. Both operators use pipelined dividers.
`timescale 1ns / 1ps

module hdr_tone_mapper_top #(
   parameter int EV_MIN = -128,
   parameter int EV_MAX = 127
) (
   input  logic        clock,
   input  logic        reset,
   htm_req_if.sink     req_ch,
   htm_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import htm_pkg::*;

   localparam logic signed [7:0] EV_LO = 8'(EV_MIN);
   localparam logic signed [7:0] EV_HI = 8'(EV_MAX);

   logic              op_ff;
   logic signed [7:0] ev_ff;
   logic signed [7:0] evc;
   logic [7:0]        u;
   logic              csr_wr;

   logic       accept;
   logic       exp_vld [3];
   lin_type    exp_lin [3];
   logic       all_exp_vld;

   logic        pbr_vld;
   q16_type     pbr_r, pbr_g, pbr_b;
   logic        aces_vld [3];
   q16_type     aces_y [3];
   logic        aces_all;

   logic              push, pop;
   rgb_out_type       push_data;
   rgb_out_type       mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  inflight_ff, inflight_in;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = csr_paddr[2] ? {24'b0, ev_ff} : {31'b0, op_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= 1'b0;
         ev_ff <= '0;
      end else if (csr_wr) begin
         if (csr_paddr[2]) begin
            ev_ff <= csr_pwdata[7:0];
         end else begin
            op_ff <= csr_pwdata[0];
         end
      end
   end

   always_comb begin
      evc = ev_ff;
      if (evc < EV_LO) evc = EV_LO;
      if (evc > EV_HI) evc = EV_HI;
   end
   assign u = {~evc[7], evc[6:0]};

   // front end
   assign accept       = req_ch.valid & req_ch.ready;
   assign req_ch.ready = (inflight_ff < CNT_W'(FIFO_DEPTH));

   htm_exp u_exp_r (.clock(clock), .reset(reset), .in_vld(accept), .in_raw(req_ch.red_in),
                    .in_u(u), .out_vld(exp_vld[0]), .out_lin(exp_lin[0]));
   htm_exp u_exp_g (.clock(clock), .reset(reset), .in_vld(accept), .in_raw(req_ch.green_in),
                    .in_u(u), .out_vld(exp_vld[1]), .out_lin(exp_lin[1]));
   htm_exp u_exp_b (.clock(clock), .reset(reset), .in_vld(accept), .in_raw(req_ch.blue_in),
                    .in_u(u), .out_vld(exp_vld[2]), .out_lin(exp_lin[2]));

   assign all_exp_vld = exp_vld[0] & exp_vld[1] & exp_vld[2];

   htm_pbr u_pbr (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (all_exp_vld & ~op_ff),
      .in_red    (exp_lin[0]),
      .in_green  (exp_lin[1]),
      .in_blue   (exp_lin[2]),
      .out_vld   (pbr_vld),
      .out_red   (pbr_r),
      .out_green (pbr_g),
      .out_blue  (pbr_b)
   );

   for (genvar i = 0; i < 3; i++) begin : g_aces
      htm_aces u_aces (
         .clock   (clock),
         .reset   (reset),
         .in_vld  (all_exp_vld & op_ff),
         .in_x    (exp_lin[i]),
         .out_vld (aces_vld[i]),
         .out_y   (aces_y[i])
      );
   end

   assign aces_all = aces_vld[0] & aces_vld[1] & aces_vld[2];

   // output FIFO; credits keep it from overflowing
   assign push      = pbr_vld | aces_all;
   assign push_data = aces_all
                    ? rgb_out_type'{red: aces_y[0], green: aces_y[1], blue: aces_y[2]}
                    : rgb_out_type'{red: pbr_r, green: pbr_g, blue: pbr_b};
   assign pop       = rsp_ch.valid & rsp_ch.ready;

   assign rsp_ch.valid     = (count_ff != '0);
   assign rsp_ch.red_out   = mem_ff[rd_ptr_ff].red;
   assign rsp_ch.green_out = mem_ff[rd_ptr_ff].green;
   assign rsp_ch.blue_out  = mem_ff[rd_ptr_ff].blue;

   always_comb begin
      count_in    = count_ff;
      inflight_in = inflight_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
      case ({accept, pop})
         2'b10:   inflight_in = inflight_ff + 1'b1;
         2'b01:   inflight_in = inflight_ff - 1'b1;
         default: inflight_in = inflight_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         inflight_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff    <= count_in;
         inflight_ff <= inflight_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`include "hdr_tone_mapper_top_macros.svh"

   `HTM_ASSERT(a_one_operator, !(pbr_vld && aces_all), "both operator paths delivered a beat")
   `HTM_ASSERT(a_credit_covers_fifo, count_ff <= inflight_ff, "FIFO holds more than accepted")
   `HTM_ASSERT(a_no_push_when_full, !(push && count_ff == CNT_W'(FIFO_DEPTH)), "FIFO overflow")
   `HTM_ASSERT_NEXT(a_pop_frees_credit, pop && !accept, inflight_ff == $past(inflight_ff) - 1'b1, "credit not returned on pop")

endmodule

[bench/hdr_tone_mapper_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdr_tone_mapper_top_test
// Self-checking bench for the HDR tone mapper. A directed table of pixels
// and settings runs first, then random pixels over operator and exposure
// settings at the limits and at random. Both channel sides stall at random.
// Every result is checked against a bit-exact integer model of exposure,
// neutral and filmic operators, or against a value given in the table.
// ----------------------------------------------------------------------------

module hdr_tone_mapper_top_test;
   import htm_pkg::*;

   localparam int        EV_LO        = -128;
   localparam int        EV_HI        = 127;
   localparam logic [2:0] OP_SEL_ADDR = 3'd0;
   localparam logic [2:0] EV_ADDR     = 3'd4;
   localparam int        DRAIN_CYCLES = 40;
   localparam int        CYCLE_LIMIT  = 200000;
   localparam int        N_PHASES     = 8;
   localparam int        N_RANDOM     = 700;
   localparam int        N_TABLE_PHASES = 7;

   typedef struct {
      bit      op;
      int      ev;
      int      r, g, b;
      bit      known;
      q16_type er, eg, eb;
   } pix_row_type;

   typedef struct {
      bit      known;
      q16_type r, g, b;
   } typed_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   htm_req_if req_bus ();
   htm_rsp_if rsp_bus ();

   hdr_tone_mapper_top #(.EV_MIN(EV_LO), .EV_MAX(EV_HI)) DUT (
      .clock(clock), .reset(reset), .req_ch(req_bus.sink), .rsp_ch(rsp_bus.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mapper settings as the block holds them
   bit          op_sel;
   logic [7:0]  ev_reg;

   rgb_out_type pixel_q[$];
   typed_type   typed_q[$];
   int          errors, checked, cycles;
   bit          rsp_quiet;

   const longint unsigned exp_steps[16] = '{
      65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752,
      92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515};

   function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
      return (n + (d >> 1)) / d;
   endfunction

   function automatic longint unsigned expose(hdr_type raw);
      longint unsigned x, p, v;
      int ev, u, k;
      x = raw[23] ? 0 : longint'(raw[22:0]);
      ev = int'($signed(ev_reg));
      if (ev < EV_LO) ev = EV_LO;
      if (ev > EV_HI) ev = EV_HI;
      u = ev + 128;
      k = (u >> 4) - 8;
      p = x * exp_steps[u & 15];
      if (k >= 0)
         v = ((p << k) + 32768) >> 16;
      else
         v = (p + (64'd1 << (15 - k))) >> (16 - k);
      return v > 8388607 ? 8388607 : v;
   endfunction

   function automatic longint unsigned filmic(longint unsigned x);
      longint unsigned num, den, q;
      if (x >= 524288) return 65536;
      num = (164495 * x * x + 1966 * x * 65536) >> 16;
      den = (159252 * x * x + 38666 * x * 65536 + (64'd9175 << 32)) >> 16;
      q = rdiv(num << 16, den);
      return q > 65536 ? 65536 : q;
   endfunction

   function automatic rgb_out_type tone_map_pixel(hdr_type ri, hdr_type gi, hdr_type bi);
      longint unsigned c[3], col[3], o[3];
      longint unsigned d, off, peak, np, diff, t, desat, s;
      longint unsigned dd = 65536 - 49807;
      rgb_out_type res;
      c[0] = expose(ri);
      c[1] = expose(gi);
      c[2] = expose(bi);
      if (op_sel) begin
         for (int i = 0; i < 3; i++) o[i] = filmic(c[i]);
      end else begin
         d = c[0];
         if (c[1] < d) d = c[1];
         if (c[2] < d) d = c[2];
         off = (d < 5243) ? d - rdiv(25 * d * d, 64'd1 << 18) : 2621;
         peak = 0;
         for (int i = 0; i < 3; i++) begin
            col[i] = c[i] - off;
            if (col[i] > peak) peak = col[i];
         end
         if (peak < 49807) begin
            for (int i = 0; i < 3; i++) o[i] = col[i];
         end else begin
            np = 65536 - rdiv(dd * dd, peak + dd - 49807);
            // rounding can push the new peak past the old one: no desaturation then
            diff = peak > np ? peak - np : 0;
            t = 65536 + rdiv(9830 * diff, 65536);
            desat = 65536 - rdiv(64'd1 << 32, t);
            for (int i = 0; i < 3; i++) begin
               s = rdiv(col[i] * np, peak);
               if (s > np) s = np;
               o[i] = s + rdiv((np - s) * desat, 65536);
            end
         end
      end
      res.red   = o[0][16:0];
      res.green = o[1][16:0];
      res.blue  = o[2][16:0];
      return res;
   endfunction

   task automatic report(string what, q16_type got, q16_type want);
      errors++;
      $display("mismatch %s: got %0d expected %0d (beat %0d)", what, got, want, checked);
   endtask

   // scoreboard: predict on accepted input beats, check accepted output beats
   always @(posedge clock) begin
      rgb_out_type want;
      typed_type hint;
      if (!reset) begin
         cycles++;
         if (req_bus.valid && req_bus.ready) begin
            want = tone_map_pixel(req_bus.red_in, req_bus.green_in, req_bus.blue_in);
            hint = typed_q.pop_front();
            if (hint.known) begin
               want.red   = hint.r;
               want.green = hint.g;
               want.blue  = hint.b;
            end
            pixel_q.push_back(want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pixel_q.size() == 0) begin
               errors++;
               $display("unexpected output beat");
            end else begin
               want = pixel_q.pop_front();
               if (rsp_bus.red_out !== want.red) report("red", rsp_bus.red_out, want.red);
               if (rsp_bus.green_out !== want.green)
                  report("green", rsp_bus.green_out, want.green);
               if (rsp_bus.blue_out !== want.blue)
                  report("blue", rsp_bus.blue_out, want.blue);
            end
            checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", pixel_q.size());
         $display("hdr_tone_mapper_top test failed");
         $finish;
      end
   end

   // output side: random stalls, with quiet stretches
   initial begin
      int n;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = rsp_quiet ? 0 : $urandom_range(0, 4);
         if (n > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == OP_SEL_ADDR) op_sel = data[0];
      else if (addr == EV_ADDR) ev_reg = data[7:0];
   endtask

   task automatic drain();
      while (pixel_q.size() != 0 || typed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // settings change only with the pipe empty; junk in the upper bits must be dropped
   task automatic set_mode(bit op, int ev);
      drain();
      csr_write(OP_SEL_ADDR, {$urandom() & 32'hFFFF_FFFE} | op);
      csr_write(EV_ADDR, {$urandom() & 32'hFFFF_FF00} | (ev & 8'hFF));
   endtask

   task automatic send_pixel(int r, int g, int b, bit quiet, typed_type hint);
      int n;
      n = quiet ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
         req_bus.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      typed_q.push_back(hint);
      req_bus.valid    <= 1'b1;
      req_bus.red_in   <= r[23:0];
      req_bus.green_in <= g[23:0];
      req_bus.blue_in  <= b[23:0];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   function automatic int rand_channel();
      case ($urandom_range(0, 6))
         0, 1: return int'($urandom() & 24'hFFFFFF) - ((($urandom() & 1) != 0) ? 0 : 0);
         2:    return $urandom_range(0, 131072);
         3:    return $urandom_range(0, 6000);
         4:    return $urandom_range(40000, 70000);
         5:    return -int'($urandom_range(1, 8388608));
         default: return $urandom_range(524288, 8388607);
      endcase
   endfunction

   pix_row_type table_rows[$] = '{
      '{0, 0, 0, 0, 0, 1, 0, 0, 0},
      '{0, 0, -8388608, -8388608, -8388608, 1, 0, 0, 0},
      '{0, 0, 8388607, 8388607, 8388607, 0, 0, 0, 0},
      '{0, 0, 65536, 32768, 4096, 0, 0, 0, 0},
      '{0, 0, 49807, 5242, 5243, 0, 0, 0, 0},
      '{0, 0, 52428, 52000, 51000, 0, 0, 0, 0},
      '{0, 0, 8388607, 0, -1, 0, 0, 0, 0},
      '{0, -128, 8388607, 4194304, 100, 0, 0, 0, 0},
      '{0, 127, 65536, 20000, 1, 0, 0, 0, 0},
      '{0, 127, 8388607, 8388607, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0, 1, 0, 0, 0},
      '{1, 0, -1, -8388608, -5, 1, 0, 0, 0},
      '{1, 0, 524288, 8388607, 600000, 1, 65536, 65536, 65536},
      '{1, 0, 524287, 65536, 1, 0, 0, 0, 0},
      '{1, 0, 32768, 131072, 13107, 0, 0, 0, 0},
      '{1, 127, 65536, 200000, 3, 0, 0, 0, 0},
      '{1, -128, 8388607, 131072, 65536, 0, 0, 0, 0},
      '{1, -1, 100000, 7, 300000, 0, 0, 0, 0}
   };

   initial begin
      typed_type hint;
      bit     cur_op;
      int     cur_ev;
      int     per_phase;
      bit     quiet;
      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      req_bus.valid    = 1'b0;
      req_bus.red_in   = '0;
      req_bus.green_in = '0;
      req_bus.blue_in  = '0;
      op_sel = 1'b0;
      ev_reg = '0;
      errors = 0;
      checked = 0;
      cycles = 0;
      rsp_quiet = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: first rows run on reset settings
      cur_op = 1'b0;
      cur_ev = 0;
      foreach (table_rows[i]) begin
         if (table_rows[i].op != cur_op || table_rows[i].ev != cur_ev) begin
            req_bus.valid <= 1'b0;
            set_mode(table_rows[i].op, table_rows[i].ev);
            cur_op = table_rows[i].op;
            cur_ev = table_rows[i].ev;
         end
         hint.known = table_rows[i].known;
         hint.r = table_rows[i].er;
         hint.g = table_rows[i].eg;
         hint.b = table_rows[i].eb;
         send_pixel(table_rows[i].r, table_rows[i].g, table_rows[i].b, 1'b0, hint);
      end

      hint.known = 1'b0;
      per_phase = N_RANDOM / N_PHASES;
      for (int ph = 0; ph < N_PHASES; ph++) begin
         req_bus.valid <= 1'b0;
         case (ph)
            0: set_mode(1'b0, EV_LO);
            1: set_mode(1'b1, EV_HI);
            2: set_mode(1'b0, EV_HI);
            3: set_mode(1'b1, EV_LO);
            default: set_mode($urandom_range(0, 1), $urandom_range(0, 255) - 128);
         endcase
         for (int j = 0; j < per_phase; j++) begin
            // alternate runs of back-to-back beats with stalled ones
            quiet = ((j / 20) % 3) == 1;
            rsp_quiet = ((j / 15) % 4) == 2;
            send_pixel(rand_channel(), rand_channel(), rand_channel(), quiet, hint);
         end
      end
      req_bus.valid <= 1'b0;
      rsp_quiet = 1'b0;
      drain();

      $display("%0d pixels checked over %0d setting phases, both operators,", checked,
               N_PHASES + N_TABLE_PHASES);
      $display("exposure at both limits, random stalls on both channels");
      if (errors == 0) begin
         $display("hdr_tone_mapper_top test passed");
      end else begin
         $display("hdr_tone_mapper_top test failed");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/htm_pkg.sv
rtl/htm_ifs.sv
rtl/htm_div.sv
rtl/htm_exp.sv
rtl/htm_pbr.sv
rtl/htm_aces.sv
rtl/hdr_tone_mapper_top.sv
bench/hdr_tone_mapper_top_test.sv
